// ===== sv/d8fd_pkg.sv =====
// Shared types, constants and helper functions of the D8 flow direction unit.
package d8fd_pkg;

   localparam int ELEV_BITS      = 32;
   localparam int NODATA_BITS    = 32;
   localparam int TOL_BITS       = 16;
   localparam int DROP_BITS      = ELEV_BITS + 1;
   localparam int TIE_BITS       = DROP_BITS + 1;
   localparam int CELLS          = 9;
   localparam int CENTRE         = 4;
   localparam int CELL_IDX_BITS  = 4;
   localparam int DIR_BITS       = 8;
   localparam int STATUS_BITS    = 2;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int SCALE_BITS     = 16;
   localparam int PROD_BITS      = DROP_BITS + SCALE_BITS;
   localparam int BACK_STAGES    = 5;

   localparam logic [SCALE_BITS-1:0] INV_SQRT2_Q16 = 16'd46341;
   localparam logic [PROD_BITS-1:0]  ROUND_HALF    = PROD_BITS'(32768);
   localparam logic [CELLS-1:0]      DIAG_MASK     = 9'b101000101;

   localparam logic [STATUS_BITS-1:0] STATUS_VALID  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FLAT   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NODATA = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODATA    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIR_MODE  = 2'd2;

   localparam logic [NODATA_BITS-1:0] NODATA_RESET    = 32'h8000_0000;
   localparam logic [TOL_BITS-1:0]    TOLERANCE_RESET = 16'd1;
   localparam logic                   MODE_MIDDLE     = 1'b0;
   localparam logic                   MODE_MASK       = 1'b1;

   typedef struct packed {
      logic signed [ELEV_BITS-1:0] elev_nw;
      logic signed [ELEV_BITS-1:0] elev_n;
      logic signed [ELEV_BITS-1:0] elev_ne;
      logic signed [ELEV_BITS-1:0] elev_w;
      logic signed [ELEV_BITS-1:0] elev_center;
      logic signed [ELEV_BITS-1:0] elev_e;
      logic signed [ELEV_BITS-1:0] elev_sw;
      logic signed [ELEV_BITS-1:0] elev_s;
      logic signed [ELEV_BITS-1:0] elev_se;
   } req_type;

   typedef struct packed {
      logic [DIR_BITS-1:0]    direction;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic signed [NODATA_BITS-1:0] nodata_value;
      logic [TOL_BITS-1:0]           tolerance;
      logic                          dir_mode;
   } cfg_type;

   typedef logic signed [DROP_BITS-1:0] drop_type;
   typedef drop_type [CELLS-1:0] drops_type;

   typedef struct packed {
      logic      nodata;
      drops_type drops;
   } entry_type;

   function automatic logic [DIR_BITS-1:0] dir_bit(input logic [CELL_IDX_BITS-1:0] idx);
      logic [DIR_BITS-1:0] bits;
      case (idx)
         4'd0: bits = 8'd32;
         4'd1: bits = 8'd64;
         4'd2: bits = 8'd128;
         4'd3: bits = 8'd16;
         4'd5: bits = 8'd1;
         4'd6: bits = 8'd8;
         4'd7: bits = 8'd4;
         4'd8: bits = 8'd2;
         default: bits = '0;
      endcase
      return bits;
   endfunction

   function automatic logic [DIR_BITS-1:0] tie_bitmask(input logic [CELLS-1:0] ties);
      logic [DIR_BITS-1:0] bits;
      bits = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (ties[i]) begin
            bits = bits | dir_bit(CELL_IDX_BITS'(i));
         end
      end
      return bits;
   endfunction

   function automatic logic [CELL_IDX_BITS-1:0] middle_tie(input logic [CELLS-1:0] ties);
      logic [CELL_IDX_BITS-1:0] cnt;
      logic [CELL_IDX_BITS-1:0] want;
      logic [CELL_IDX_BITS-1:0] seen;
      logic [CELL_IDX_BITS-1:0] idx;
      cnt = '0;
      for (int i = 0; i < CELLS; i++) begin
         cnt = cnt + CELL_IDX_BITS'(ties[i]);
      end
      want = cnt >> 1;
      seen = '0;
      idx  = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (ties[i]) begin
            if (seen == want) begin
               idx = CELL_IDX_BITS'(i);
            end
            seen = seen + 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

// ===== sv/d8fd_front.sv =====
// Front end: accepts a window, flags no-data cells and forms the raw drops.
module d8fd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  d8fd_pkg::req_type    req_data,
   input  d8fd_pkg::cfg_type    cfg,
   input  logic                 queue_full,
   output logic                 push,
   output d8fd_pkg::entry_type  push_data
);

   logic                        valid_ff;
   logic                        valid_in;
   d8fd_pkg::entry_type         entry_ff;
   d8fd_pkg::entry_type         entry_in;
   logic                        accept;
   logic signed [d8fd_pkg::ELEV_BITS-1:0] elev [d8fd_pkg::CELLS];
   logic [d8fd_pkg::CELLS-1:0]  near;
   d8fd_pkg::drop_type          diff [d8fd_pkg::CELLS];
   logic [d8fd_pkg::DROP_BITS-1:0] mag [d8fd_pkg::CELLS];

   assign push      = valid_ff && !queue_full;
   assign busy      = valid_ff && queue_full;
   assign accept    = start && !busy;
   assign push_data = entry_ff;

   assign elev[0] = req_data.elev_nw;
   assign elev[1] = req_data.elev_n;
   assign elev[2] = req_data.elev_ne;
   assign elev[3] = req_data.elev_w;
   assign elev[4] = req_data.elev_center;
   assign elev[5] = req_data.elev_e;
   assign elev[6] = req_data.elev_sw;
   assign elev[7] = req_data.elev_s;
   assign elev[8] = req_data.elev_se;

   always_comb begin
      for (int i = 0; i < d8fd_pkg::CELLS; i++) begin
         diff[i] = d8fd_pkg::DROP_BITS'(elev[i])
                 - d8fd_pkg::DROP_BITS'(cfg.nodata_value);
         mag[i]  = diff[i][d8fd_pkg::DROP_BITS-1] ? 
                   d8fd_pkg::DROP_BITS'(-diff[i]) : d8fd_pkg::DROP_BITS'(diff[i]);
         near[i] = mag[i] < d8fd_pkg::DROP_BITS'(cfg.tolerance);
         entry_in.drops[i] = d8fd_pkg::DROP_BITS'(elev[d8fd_pkg::CENTRE])
                           - d8fd_pkg::DROP_BITS'(elev[i]);
      end
      entry_in.nodata = |near;
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== sv/d8fd_queue.sv =====
// Short queue between front end and back end.
module d8fd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  d8fd_pkg::entry_type  push_data,
   output logic                 full,
   output logic                 pop,
   output d8fd_pkg::entry_type  pop_data
);

   d8fd_pkg::entry_type                     slot_ff [d8fd_pkg::QUEUE_DEPTH];
   logic [d8fd_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [d8fd_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_in;
   logic [d8fd_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [d8fd_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_in;
   logic [d8fd_pkg::QUEUE_CNT_BITS-1:0]     count_ff;
   logic [d8fd_pkg::QUEUE_CNT_BITS-1:0]     count_in;

   assign full     = count_ff == d8fd_pkg::QUEUE_CNT_BITS'(d8fd_pkg::QUEUE_DEPTH);
   assign pop      = count_ff != '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + d8fd_pkg::QUEUE_CNT_BITS'(push)
                - d8fd_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/d8fd_back.sv =====
// Back end: scales diagonal drops, finds the steepest drop, resolves ties.
module d8fd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop,
   input  d8fd_pkg::entry_type  pop_data,
   input  d8fd_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   output d8fd_pkg::rsp_type    rsp_data
);

   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                        s1_nodata_ff, s2_nodata_ff, s3_nodata_ff, s4_nodata_ff;
   d8fd_pkg::drops_type         s1_drops_ff, s2_drops_ff, s3_drops_ff;
   d8fd_pkg::drops_type         s1_drops_in;
   d8fd_pkg::drop_type          row_max_ff [3];
   d8fd_pkg::drop_type          row_max_in [3];
   d8fd_pkg::drop_type          top_ff;
   d8fd_pkg::drop_type          top_in;
   logic [d8fd_pkg::CELLS-1:0]  ties_ff;
   logic [d8fd_pkg::CELLS-1:0]  ties_in;
   logic                        flat_ff;
   logic                        flat_in;
   logic                        rsp_valid_ff;
   d8fd_pkg::rsp_type           rsp_ff;
   d8fd_pkg::rsp_type           rsp_in;
   logic [d8fd_pkg::DROP_BITS-1:0] mag [d8fd_pkg::CELLS];
   logic [d8fd_pkg::PROD_BITS-1:0] prod [d8fd_pkg::CELLS];
   logic [d8fd_pkg::DROP_BITS-1:0] scaled [d8fd_pkg::CELLS];
   logic signed [d8fd_pkg::TIE_BITS-1:0] gap [d8fd_pkg::CELLS];

   function automatic d8fd_pkg::drop_type max3(input d8fd_pkg::drop_type a,
                                               input d8fd_pkg::drop_type b,
                                               input d8fd_pkg::drop_type c);
      d8fd_pkg::drop_type m;
      m = ($signed(a) > $signed(b)) ? a : b;
      m = ($signed(c) > $signed(m)) ? c : m;
      return m;
   endfunction

   always_comb begin
      for (int i = 0; i < d8fd_pkg::CELLS; i++) begin
         mag[i]    = pop_data.drops[i][d8fd_pkg::DROP_BITS-1] ?
                     d8fd_pkg::DROP_BITS'(-$signed(pop_data.drops[i])) :
                     d8fd_pkg::DROP_BITS'(pop_data.drops[i]);
         prod[i]   = d8fd_pkg::PROD_BITS'(mag[i]) * d8fd_pkg::PROD_BITS'(d8fd_pkg::INV_SQRT2_Q16)
                   + d8fd_pkg::ROUND_HALF;
         scaled[i] = prod[i][d8fd_pkg::PROD_BITS-1:d8fd_pkg::SCALE_BITS];
         if (!d8fd_pkg::DIAG_MASK[i]) begin
            s1_drops_in[i] = pop_data.drops[i];
         end else if (pop_data.drops[i][d8fd_pkg::DROP_BITS-1]) begin
            s1_drops_in[i] = d8fd_pkg::DROP_BITS'(-$signed(scaled[i]));
         end else begin
            s1_drops_in[i] = scaled[i];
         end
      end
   end

   always_comb begin
      row_max_in[0] = max3(s1_drops_ff[0], s1_drops_ff[1], s1_drops_ff[2]);
      row_max_in[1] = max3(s1_drops_ff[3], s1_drops_ff[4], s1_drops_ff[5]);
      row_max_in[2] = max3(s1_drops_ff[6], s1_drops_ff[7], s1_drops_ff[8]);
      top_in        = max3(row_max_ff[0], row_max_ff[1], row_max_ff[2]);
   end

   always_comb begin
      for (int i = 0; i < d8fd_pkg::CELLS; i++) begin
         gap[i]     = d8fd_pkg::TIE_BITS'($signed(top_ff))
                    - d8fd_pkg::TIE_BITS'($signed(s3_drops_ff[i]));
         ties_in[i] = gap[i] < $signed(d8fd_pkg::TIE_BITS'(cfg.tolerance));
      end
      flat_in = $signed(top_ff) < $signed(d8fd_pkg::DROP_BITS'(cfg.tolerance));
   end

   always_comb begin
      rsp_in.direction = '0;
      rsp_in.status    = d8fd_pkg::STATUS_VALID;
      if (s4_nodata_ff) begin
         rsp_in.status = d8fd_pkg::STATUS_NODATA;
      end else if (flat_ff || ties_ff == '0) begin
         rsp_in.status = d8fd_pkg::STATUS_FLAT;
      end else if (cfg.dir_mode == d8fd_pkg::MODE_MASK) begin
         rsp_in.direction = d8fd_pkg::tie_bitmask(ties_ff);
      end else begin
         rsp_in.direction = d8fd_pkg::DIR_BITS'(d8fd_pkg::middle_tie(ties_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_nodata_ff  <= pop_data.nodata;
      s1_drops_ff   <= s1_drops_in;
      s2_nodata_ff  <= s1_nodata_ff;
      s2_drops_ff   <= s1_drops_ff;
      row_max_ff    <= row_max_in;
      s3_nodata_ff  <= s2_nodata_ff;
      s3_drops_ff   <= s2_drops_ff;
      top_ff        <= top_in;
      s4_nodata_ff  <= s3_nodata_ff;
      ties_ff       <= ties_in;
      flat_ff       <= flat_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pop_to_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##(d8fd_pkg::BACK_STAGES) rsp_valid)
      else $error("popped beat did not reach the result port on time");

   a_reject_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != d8fd_pkg::STATUS_VALID |-> rsp_data.direction == '0)
      else $error("flat or no-data beat carries a direction");

   a_top_floored: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> !top_ff[d8fd_pkg::DROP_BITS-1])
      else $error("steepest drop below zero");

endmodule

// ===== sv/d8_flow_direction_unit.sv =====
// Top level of the D8 flow direction unit: register file and front/queue/back.
// A started window goes via front register, queue and back stages to rsp_valid.
// Throughput: one window per cycle; busy rises only if the queue fills.
// Each result shows for one cycle; the receiver cannot stall.
// Reset: synchronous; empties the pipeline and queue, restores register defaults.
module d8_flow_direction_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  d8fd_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   output d8fd_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [d8fd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [d8fd_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   d8fd_pkg::cfg_type    cfg_ff;
   d8fd_pkg::cfg_type    cfg_in;
   logic                 push;
   logic                 queue_full;
   logic                 pop;
   d8fd_pkg::entry_type  push_data;
   d8fd_pkg::entry_type  pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            d8fd_pkg::CSR_NODATA:
               cfg_in.nodata_value = d8fd_pkg::NODATA_BITS'(csr_data);
            d8fd_pkg::CSR_TOLERANCE:
               cfg_in.tolerance = csr_data[d8fd_pkg::TOL_BITS-1:0];
            d8fd_pkg::CSR_DIR_MODE:
               cfg_in.dir_mode = csr_data[0];
            default:
               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nodata_value <= d8fd_pkg::NODATA_RESET;
         cfg_ff.tolerance    <= d8fd_pkg::TOLERANCE_RESET;
         cfg_ff.dir_mode     <= d8fd_pkg::MODE_MIDDLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   d8fd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   d8fd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   d8fd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_data  (pop_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
